// ===== design/slm_pkg.sv =====
package slm_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int ENERGY_W    = 56;
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int SUM_W       = SAMPLE_BITS + 4;
  localparam int RECIP_W     = 32;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 35;
  localparam int ROOT_W      = ENERGY_W / 2;
  localparam int SREM_W      = ROOT_W + 2;
  localparam int DIV_STEPS   = ENERGY_W;
  localparam int SQRT_STEPS  = ROOT_W;
  localparam int STEP_W      = 6;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          last_of_block;
  } slm_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mono_out;
    logic                          meter_valid;
    logic [SAMPLE_BITS-1:0]        smoothed_peak;
    logic [SAMPLE_BITS-1:0]        smoothed_rms;
    logic                          block_overflow;
  } slm_out_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mono;
    logic [SAMPLE_BITS-1:0]        mag;
    logic                          last;
  } slm_work_t;

  typedef struct packed {
    logic      push;
    slm_work_t data;
  } slm_qwr_t;

  typedef enum logic [1:0] {
    R_IDLE,
    R_DIV,
    R_SQRT,
    R_DONE
  } slm_root_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SQ,
    B_ACC,
    B_ROOT,
    B_PSUM,
    B_PMUL,
    B_RSUM,
    B_RMUL,
    B_RLVL,
    B_EMIT
  } slm_back_state_t;

endpackage

// ===== design/stereo_level_meter_top.sv =====
// Channel   Direction  Handshake           Payload
// in_       input      in_push / in_full    slm_in_t: left, right, last of block
// out_      output     out_empty / out_pop  slm_out_t: mono mix and meter levels
//
// The front registers the mono mix and magnitude and hands items to a
// four-entry queue, so it keeps accepting while the back end is busy.
// In the back end an item that does not close a block passes through squaring on the
// shared multiplier, accumulation and hand-over; a closing item passes through square and
// accumulate, the bit-serial divider (56 steps), root (28 steps) and its done state,
// the peak and RMS smoothing sums and multiplies, and the hand-over.
// Reset is synchronous and active low and clears all levels and accumulators.
// A result waits in the output register while further items are accepted.
module stereo_level_meter_top #(
  parameter int MAX_BLOCK = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  slm_pkg::slm_in_t  in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output slm_pkg::slm_out_t out_data
);
  import slm_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);

  slm_qwr_t               q_wr;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_empty;
  slm_work_t              q_data;
  logic                   root_start;
  logic [ENERGY_W-1:0]    root_energy;
  logic [CNT_W-1:0]       root_count;
  logic                   root_done;
  logic [SAMPLE_BITS-1:0] root_value;

  slm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_full  (q_full),
    .q_wr    (q_wr)
  );

  slm_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_data  (q_data)
  );

  slm_root #(
    .CNT_W (CNT_W)
  ) u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .dividend (root_energy),
    .divisor  (root_count),
    .done     (root_done),
    .root     (root_value)
  );

  slm_back #(
    .MAX_BLOCK (MAX_BLOCK),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .root_start  (root_start),
    .root_energy (root_energy),
    .root_count  (root_count),
    .root_done   (root_done),
    .root_value  (root_value),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data)
  );

endmodule

// ===== design/slm_front.sv =====
module slm_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  slm_pkg::slm_in_t in_data,
  input  logic            q_full,
  output slm_pkg::slm_qwr_t q_wr
);
  import slm_pkg::*;

  logic                   valid_r, valid_nxt;
  slm_work_t              work_r;
  logic [SAMPLE_BITS:0]   sum;
  logic [SAMPLE_BITS-1:0] mono;
  logic                   accept;

  assign sum    = {in_data.left_sample[SAMPLE_BITS-1], in_data.left_sample}
                + {in_data.right_sample[SAMPLE_BITS-1], in_data.right_sample};
  assign mono   = sum[SAMPLE_BITS:1];
  assign in_full = valid_r && q_full;
  assign accept = in_push && !in_full;

  assign q_wr.push = valid_r && !q_full;
  assign q_wr.data = work_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_wr.push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work_r.mono <= mono;
      work_r.mag  <= mono[SAMPLE_BITS-1] ? (~mono + 1'b1) : mono;
      work_r.last <= in_data.last_of_block;
    end
  end

endmodule

// ===== design/slm_fifo.sv =====
module slm_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  slm_pkg::slm_qwr_t  q_wr,
  output logic               q_full,
  input  logic               q_pop,
  output logic               q_empty,
  output slm_pkg::slm_work_t q_data
);
  import slm_pkg::*;

  localparam int CQ_W = QPTR_W + 1;

  slm_work_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_W-1:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign q_full  = (count_r == CQ_W'(QDEPTH));
  assign q_empty = (count_r == '0);
  assign do_push = q_wr.push && !q_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CQ_W'(QDEPTH))
    else $error("Queue holds more items than it has entries.");
`endif

endmodule

// ===== design/slm_root.sv =====
module slm_root #(
  parameter int CNT_W = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [slm_pkg::ENERGY_W-1:0]    dividend,
  input  logic [CNT_W-1:0]                divisor,
  output logic                            done,
  output logic [slm_pkg::SAMPLE_BITS-1:0] root
);
  import slm_pkg::*;

  slm_root_state_t   state_r, state_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    div_r, div_nxt;
  logic [ENERGY_W-1:0] quo_r, quo_nxt;
  logic [SREM_W-1:0]   srem_r, srem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [CNT_W:0]      div_trial, div_diff;
  logic [SREM_W+1:0]   sq_trial, sq_test, sq_diff;

  assign div_trial = {rem_r, quo_r[ENERGY_W-1]};
  assign div_diff  = div_trial - {1'b0, div_r};
  assign sq_trial  = {srem_r, quo_r[ENERGY_W-1 -: 2]};
  assign sq_test   = {2'b00, root_r, 2'b01};
  assign sq_diff   = sq_trial - sq_test;
  assign root      = root_r[SAMPLE_BITS-1:0];

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    quo_nxt   = quo_r;
    srem_nxt  = srem_r;
    root_nxt  = root_r;
    step_nxt  = step_r;
    done      = 1'b0;
    unique case (state_r)
      R_IDLE: begin
        if (start) begin
          rem_nxt   = '0;
          div_nxt   = divisor;
          quo_nxt   = dividend;
          step_nxt  = '0;
          state_nxt = R_DIV;
        end
      end
      R_DIV: begin
        if (div_trial >= {1'b0, div_r}) begin
          rem_nxt = div_diff[CNT_W-1:0];
          quo_nxt = {quo_r[ENERGY_W-2:0], 1'b1};
        end else begin
          rem_nxt = div_trial[CNT_W-1:0];
          quo_nxt = {quo_r[ENERGY_W-2:0], 1'b0};
        end
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          step_nxt  = '0;
          srem_nxt  = '0;
          root_nxt  = '0;
          state_nxt = R_SQRT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      R_SQRT: begin
        if (sq_trial >= sq_test) begin
          srem_nxt = sq_diff[SREM_W-1:0];
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          srem_nxt = sq_trial[SREM_W-1:0];
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        quo_nxt = {quo_r[ENERGY_W-3:0], 2'b00};
        if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
          state_nxt = R_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      R_DONE: begin
        done      = 1'b1;
        state_nxt = R_IDLE;
      end
      default: begin
        state_nxt = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    quo_r  <= quo_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
  end

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == R_DIV |-> div_r != '0)
    else $error("Block closed with a zero sample count.");
`endif

endmodule

// ===== design/slm_back.sv =====
module slm_back #(
  parameter int MAX_BLOCK = 512,
  parameter int CNT_W     = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  slm_pkg::slm_work_t              q_data,
  output logic                            q_pop,
  output logic                            root_start,
  output logic [slm_pkg::ENERGY_W-1:0]    root_energy,
  output logic [CNT_W-1:0]                root_count,
  input  logic                            root_done,
  input  logic [slm_pkg::SAMPLE_BITS-1:0] root_value,
  output logic                            out_empty,
  input  logic                            out_pop,
  output slm_pkg::slm_out_t               out_data
);
  import slm_pkg::*;

  slm_back_state_t        state_r, state_nxt;
  slm_work_t              cur_r;
  slm_out_t               out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] peak_r, peak_nxt;
  logic [ENERGY_W-1:0]    energy_r, energy_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [SAMPLE_BITS-1:0] peak_lvl_r, peak_lvl_nxt;
  logic [SAMPLE_BITS-1:0] rms_lvl_r, rms_lvl_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic                   prod_en;
  logic [SUM_W-1:0]       mul_a;
  logic [RECIP_W-1:0]     mul_b;
  logic [ENERGY_W:0]      esum;
  logic                   slot_free;
  logic                   emit;

  function automatic logic [SUM_W-1:0] nine_plus(input logic [SAMPLE_BITS-1:0] held,
                                                 input logic [SAMPLE_BITS-1:0] fresh);
    logic [SUM_W-1:0] h;
    h = {4'd0, held};
    return (h << 3) + h + {4'd0, fresh};
  endfunction

  assign slot_free = !out_valid_r || out_pop;
  assign esum      = {1'b0, energy_r} + {{(ENERGY_W + 1 - SQ_W){1'b0}}, prod_r[SQ_W-1:0]};
  assign mul_a     = (state_r == B_SQ) ? {4'd0, cur_r.mag} : sum_r;
  assign mul_b     = (state_r == B_SQ) ? {{(RECIP_W - SAMPLE_BITS){1'b0}}, cur_r.mag}
                                       : RECIP_TEN;
  assign prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_en   = (state_r == B_SQ) || (state_r == B_PMUL) || (state_r == B_RMUL);
  assign root_energy = energy_nxt;
  assign root_count  = cnt_nxt;
  assign out_empty   = !out_valid_r;
  assign out_data    = out_r;

  always_comb begin
    state_nxt    = state_r;
    out_nxt      = out_r;
    peak_nxt     = peak_r;
    energy_nxt   = energy_r;
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    peak_lvl_nxt = peak_lvl_r;
    rms_lvl_nxt  = rms_lvl_r;
    sum_nxt      = sum_r;
    root_start   = 1'b0;
    emit         = 1'b0;
    q_pop        = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = B_SQ;
        end
      end
      B_SQ: begin
        state_nxt = B_ACC;
      end
      B_ACC: begin
        if (cur_r.mag > peak_r) begin
          peak_nxt = cur_r.mag;
        end
        if (cnt_r == CNT_W'(MAX_BLOCK)) begin
          ovf_nxt = 1'b1;
        end else begin
          cnt_nxt    = cnt_r + 1'b1;
          energy_nxt = esum[ENERGY_W] ? '1 : esum[ENERGY_W-1:0];
        end
        if (cur_r.last) begin
          root_start = 1'b1;
          state_nxt  = B_ROOT;
        end else begin
          state_nxt = B_EMIT;
        end
      end
      B_ROOT: begin
        if (root_done) begin
          state_nxt = B_PSUM;
        end
      end
      B_PSUM: begin
        sum_nxt   = nine_plus(peak_lvl_r, peak_r);
        state_nxt = B_PMUL;
      end
      B_PMUL: begin
        state_nxt = B_RSUM;
      end
      B_RSUM: begin
        peak_lvl_nxt = prod_r[RECIP_SHIFT +: SAMPLE_BITS];
        sum_nxt      = nine_plus(rms_lvl_r, root_value);
        state_nxt    = B_RMUL;
      end
      B_RMUL: begin
        state_nxt = B_RLVL;
      end
      B_RLVL: begin
        rms_lvl_nxt = prod_r[RECIP_SHIFT +: SAMPLE_BITS];
        state_nxt   = B_EMIT;
      end
      B_EMIT: begin
        if (slot_free) begin
          emit                   = 1'b1;
          out_nxt.mono_out       = cur_r.mono;
          out_nxt.meter_valid    = cur_r.last;
          out_nxt.smoothed_peak  = peak_lvl_r;
          out_nxt.smoothed_rms   = rms_lvl_r;
          out_nxt.block_overflow = ovf_r;
          if (cur_r.last) begin
            peak_nxt   = '0;
            energy_nxt = '0;
            cnt_nxt    = '0;
            ovf_nxt    = 1'b0;
          end
          if (!q_empty) begin
            q_pop     = 1'b1;
            state_nxt = B_SQ;
          end else begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    out_valid_nxt = emit ? 1'b1 : (out_pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      peak_r      <= '0;
      energy_r    <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      peak_lvl_r  <= '0;
      rms_lvl_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      peak_r      <= peak_nxt;
      energy_r    <= energy_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      peak_lvl_r  <= peak_lvl_nxt;
      rms_lvl_r   <= rms_lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    sum_r <= sum_nxt;
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (prod_en) begin
      prod_r <= prod_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_BLOCK))
    else $error("Sample count ran past the block limit.");

  a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && cur_r.last) |=> (cnt_r == '0 && energy_r == '0 && peak_r == '0 && !ovf_r))
    else $error("Accumulators not cleared after a closing item.");

  a_root_wait: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> state_r == B_ROOT)
    else $error("Root result arrived while the back end was not waiting.");
`endif

endmodule
